// ===== design/slpf_pkg.sv =====
// Shared types and constants for the speaker level to PCM filler.
// No dependencies; compiled first.
package slpf_pkg;

  localparam int SPP_W       = 7;
  localparam int LEVEL_W     = 6;
  localparam int PERIOD_W    = 20;
  localparam int LEFT_W      = 21;
  localparam int VALUE_W     = 15;
  localparam int INDEX_W     = 6;
  localparam int MAX_SAMPLES = 64;
  localparam int LEVEL_SHIFT = 9;
  localparam int PROD_W      = PERIOD_W + SPP_W;
  localparam int Q_W         = 7;
  localparam int CNT_W       = 3;

  localparam logic OP_LEVEL = 1'b0;
  localparam logic OP_EOP   = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [LEVEL_W-1:0]  new_level;
    logic [PERIOD_W-1:0] period_cycles;
    logic [LEFT_W-1:0]   cycles_left;
  } in_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul_init;
    logic div_step;
    logic set_target_n;
    logic emit;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic eop;
    logic n_zero;
    logic left_lt_period;
    logic div_last;
    logic behind;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ===== design/slpf_in_if.sv =====
// Input channel for the speaker level to PCM filler: valid/ready plus item fields.
// Depends on slpf_pkg.
interface slpf_in_if;
  import slpf_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic [LEVEL_W-1:0]  new_level;
  logic [PERIOD_W-1:0] period_cycles;
  logic [LEFT_W-1:0]   cycles_left;

  modport source (output valid, opcode, new_level, period_cycles, cycles_left, input ready);
  modport sink (input valid, opcode, new_level, period_cycles, cycles_left, output ready);
endinterface

// ===== design/slpf_out_if.sv =====
// Output channel for the speaker level to PCM filler: valid/ready plus sample fields.
// Depends on slpf_pkg.
interface slpf_out_if;
  import slpf_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sample_value;
  logic [INDEX_W-1:0] sample_index;
  logic               last_of_run;

  modport source (output valid, sample_value, sample_index, last_of_run, input ready);
  modport sink (input valid, sample_value, sample_index, last_of_run, output ready);
endinterface

// ===== design/slpf_ctrl.sv =====
// Sequencing state machine of the speaker level to PCM filler.
// Depends on slpf_pkg; drives cmd_t, reads stat_t.
module slpf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  slpf_pkg::stat_t stat,
  output slpf_pkg::cmd_t  cmd
);
  import slpf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_FILL  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (stat.eop) begin
          if (stat.n_zero) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.set_target_n = 1'b1;
            state_next       = ST_FILL;
          end
        end else if (stat.n_zero || !stat.left_lt_period) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.mul_init = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!stat.behind) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/slpf_dp.sv =====
// Datapath: config register, position/level state, multiply, shift-subtract
// divider and the output word register. Depends on slpf_pkg and slpf_out_if.
module slpf_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [slpf_pkg::SPP_W-1:0]     cfg_data,
  input  slpf_pkg::in_word_t             in_word,
  input  slpf_pkg::cmd_t                 cmd,
  output slpf_pkg::stat_t                stat,
  slpf_out_if.source                     sample
);
  import slpf_pkg::*;

  logic [SPP_W-1:0]    spp;
  logic [SPP_W-1:0]    pos;
  logic [LEVEL_W-1:0]  held;
  logic                eop;
  logic [LEVEL_W-1:0]  lvl_new;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] left;
  logic [PROD_W-1:0]   rem;
  logic [PROD_W-1:0]   dvs;
  logic [Q_W-1:0]      quo;
  logic [CNT_W-1:0]    cnt;
  logic [SPP_W-1:0]    target;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic [INDEX_W-1:0]  out_index;
  logic                out_last;

  logic [SPP_W-1:0]    n_eff;
  logic [PERIOD_W-1:0] left_clamped;
  logic [PERIOD_W-1:0] diff;
  logic                ge;
  logic [Q_W-1:0]      quo_next;
  logic [SPP_W-1:0]    pos_inc;

  assign n_eff        = (spp > SPP_W'(MAX_SAMPLES)) ? SPP_W'(MAX_SAMPLES) : spp;
  assign left_clamped = in_word.cycles_left[LEFT_W-1] ? '0
                                                      : in_word.cycles_left[PERIOD_W-1:0];
  assign diff         = period - left;
  assign ge           = (rem >= dvs);
  assign quo_next     = {quo[Q_W-2:0], ge};
  assign pos_inc      = pos + SPP_W'(1);

  assign stat.eop            = eop;
  assign stat.n_zero         = (n_eff == '0);
  assign stat.left_lt_period = (left < period);
  assign stat.div_last       = (cnt == '0);
  assign stat.behind         = (pos < target);
  assign stat.last           = (pos_inc == target);
  assign stat.out_free       = !out_valid || sample.ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      spp  <= '0;
      pos  <= '0;
      held <= '0;
    end else begin
      if (cfg_we) begin
        spp <= cfg_data;
      end
      if (cmd.finish && eop) begin
        pos <= '0;
      end else if (cmd.emit) begin
        pos <= pos_inc;
      end
      if (cmd.finish && !eop) begin
        held <= lvl_new;
      end
    end
  end

  // latched item and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      eop     <= (in_word.opcode == OP_EOP);
      lvl_new <= in_word.new_level;
      period  <= in_word.period_cycles;
      left    <= left_clamped;
    end
    if (cmd.mul_init) begin
      rem <= PROD_W'(diff) * PROD_W'(n_eff);
      dvs <= {{(PROD_W-PERIOD_W-Q_W+1){1'b0}}, period, {(Q_W-1){1'b0}}};
      quo <= '0;
      cnt <= CNT_W'(Q_W-1);
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      dvs <= dvs >> 1;
      quo <= quo_next;
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.set_target_n) begin
      target <= n_eff;
    end else if (cmd.div_step && stat.div_last) begin
      target <= SPP_W'(quo_next);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (sample.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value <= {held, {LEVEL_SHIFT{1'b0}}};
      out_index <= pos[INDEX_W-1:0];
      out_last  <= stat.last;
    end
  end

  assign sample.valid        = out_valid;
  assign sample.sample_value = out_value;
  assign sample.sample_index = out_index;
  assign sample.last_of_run  = out_last;

endmodule

// ===== design/speaker_level_to_pcm_filler.sv =====
// Top level of the speaker level to PCM filler.
// Depends on slpf_pkg, slpf_in_if, slpf_out_if, slpf_ctrl and slpf_dp.
//
// Usage:
//  - item (valid/ready sink): one word per event. opcode 0 is a level change,
//    opcode 1 marks the end of a period. A word is taken when valid && ready.
//  - sample (valid/ready source): one word per PCM sample, with its buffer
//    index; last_of_run flags the final sample an event causes. Events that
//    produce nothing (sound inactive, position not behind target, countdown
//    not inside the period) give no sample word at all.
//  - cfg_we/cfg_data: writes samples_per_period (values above 64 act as 64,
//    zero turns sound off). Write only while the block is idle.
// Sequence: one event at a time: accept, setup/multiply, 7 divide steps
//  (one quotient bit per cycle, the quotient never exceeds 64), then the fill of
//  samples; an end of period skips the divide. An event that writes nothing
//  ends after setup or at the first fill check. First sample shows once the
//  fill has loaded it into the output register.
// Stall: the sample port has a single output register; a stalled receiver holds
//  the fill. After the last sample is loaded, the next event can be taken while
//  that sample still waits.
// Reset (rst, synchronous): position, held level and samples_per_period go to
//  zero, the output register empties.
module speaker_level_to_pcm_filler (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [slpf_pkg::SPP_W-1:0] cfg_data,
  slpf_in_if.sink                    item,
  slpf_out_if.source                 sample
);
  import slpf_pkg::*;

  cmd_t     cmd;
  stat_t    stat;
  in_word_t in_word;
  logic     in_ready;

  assign in_word.opcode        = item.opcode;
  assign in_word.new_level     = item.new_level;
  assign in_word.period_cycles = item.period_cycles;
  assign in_word.cycles_left   = item.cycles_left;
  assign item.ready            = in_ready;

  // sequencer: accept, setup, divide, fill
  slpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // registers, multiply/divide and output word
  slpf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .sample   (sample)
  );

  // a taken event keeps the port closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item port open right after an accept");

  // a sample that is not last of its run means the fill is still going
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    sample.valid && !sample.last_of_run |-> !item.ready)
    else $error("item port open in the middle of a run");

  // a sample is only produced while the position trails the target and the output register is free
  a_emit_behind: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.behind && stat.out_free)
    else $error("sample emitted past target or into a full register");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for speaker_level_to_pcm_filler: directed words, then random periods and noise.
// Depends on slpf_pkg, slpf_in_if, slpf_out_if and the filler RTL.
module testbench;
  import slpf_pkg::*;

  // One expected PCM sample word.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               last;
  } pcm_word_t;

  // Directed table row: either a samples_per_period write or an event word.
  // n_typed >= 0 means the sample run is written out by hand (first index,
  // sample value, n_typed samples); -1 hands the row to the predictor.
  typedef struct {
    bit               is_cfg;
    logic [SPP_W-1:0] spp;
    in_word_t         w;
    int               n_typed;
    int               first_idx;
    int               value;
  } stim_row_t;

  localparam int IDLE_PCT   = 38;
  localparam int DRAIN_WAIT = 80;  // covers the slowest event
  localparam int PHASES     = 9;
  localparam int PHASE_ITEMS = 49;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [SPP_W-1:0] cfg_data;
  bit               calm;           // suppresses idling on both sides
  int               fail_count;

  // Predictor state: register, write position, held level.
  int unsigned      m_spp;
  int unsigned      m_pos;
  logic [LEVEL_W-1:0] m_held;

  pcm_word_t        pending_pcm[$];
  stim_row_t        directed_tab[$];
  pcm_word_t        got_pcm;
  pcm_word_t        want_pcm;

  slpf_in_if  item_ch ();
  slpf_out_if pcm_ch ();

  speaker_level_to_pcm_filler dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .sample   (pcm_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor. Works out the fill target for one event, queues the sample
  // words it produces (when record is set) and updates position/level.
  // ---------------------------------------------------------------------
  function automatic void pcm_predict(input in_word_t w, input bit record);
    int unsigned n;
    int unsigned left;
    int unsigned tgt;
    int unsigned p;
    pcm_word_t   s;
    // register values above 64 act as 64
    n   = (m_spp > MAX_SAMPLES) ? MAX_SAMPLES : m_spp;
    tgt = m_pos;
    if (w.opcode == OP_LEVEL) begin
      if (n != 0) begin
        // negative countdown clamps to zero
        left = w.cycles_left[LEFT_W-1] ? 0 : int'(w.cycles_left);
        // countdown outside the period (incl. zero period) fills nothing
        if (left < w.period_cycles)
          tgt = ((w.period_cycles - left) * n) / w.period_cycles;
      end
    end else if (n != 0) begin
      tgt = n;
    end
    // position already at/past target: nothing emitted, position kept
    for (p = m_pos; p < tgt; p++) begin
      s.value = VALUE_W'(m_held) << LEVEL_SHIFT;
      s.index = INDEX_W'(p);
      s.last  = (p + 1 == tgt);
      if (record) pending_pcm.push_back(s);
    end
    if (m_pos < tgt) m_pos = tgt;
    if (w.opcode == OP_LEVEL) m_held = w.new_level;
    else m_pos = 0;
  endfunction

  function automatic stim_row_t ev_row(input logic op, input int lvl, input int per,
                                       input int left, input int n, input int first,
                                       input int val);
    stim_row_t r;
    r.is_cfg          = 1'b0;
    r.spp             = '0;
    r.w.opcode        = op;
    r.w.new_level     = LEVEL_W'(lvl);
    r.w.period_cycles = PERIOD_W'(per);
    r.w.cycles_left   = LEFT_W'(left);
    r.n_typed         = n;
    r.first_idx       = first;
    r.value           = val;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input int v);
    stim_row_t r;
    r         = ev_row(OP_LEVEL, 0, 0, 0, -1, 0, 0);
    r.is_cfg  = 1'b1;
    r.spp     = SPP_W'(v);
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input pcm_word_t want,
                                        input pcm_word_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t pcm %s: exp val %h idx %0d last %b, got val %h idx %0d last %b",
               $realtime, what, want.value, want.index, want.last,
               got.value, got.index, got.last);
  endfunction

  // ---------------------------------------------------------------------
  // Event sender. Called just after a rising edge; may idle first, then
  // presents the word at the falling edge and holds it until accepted.
  // The word stays valid afterwards; the next call replaces or lowers it, a drain lowers it.
  // ---------------------------------------------------------------------
  task automatic send_word(input in_word_t w, input int n_typed, input int first_idx,
                           input int value);
    int        k;
    pcm_word_t s;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    item_ch.valid         <= 1'b1;
    item_ch.opcode        <= w.opcode;
    item_ch.new_level     <= w.new_level;
    item_ch.period_cycles <= w.period_cycles;
    item_ch.cycles_left   <= w.cycles_left;
    do @(posedge clk); while (!item_ch.ready);
    // word taken at this edge: queue its samples
    if (n_typed >= 0) begin
      for (k = 0; k < n_typed; k++) begin
        s.value = VALUE_W'(value);
        s.index = INDEX_W'(first_idx + k);
        s.last  = (k == n_typed - 1);
        pending_pcm.push_back(s);
      end
      pcm_predict(w, 1'b0);
    end else begin
      pcm_predict(w, 1'b1);
    end
  endtask

  // Drop valid and hold off until every queued sample has been taken.
  task automatic wait_drained;
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk);
  endtask

  // Full idle: drained, plus time for an event that emits nothing.
  task automatic settle;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_spp(input int unsigned v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= SPP_W'(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
    m_spp = v & 7'h7F;
  endtask

  task automatic rand_noise;
    in_word_t w;
    w.opcode        = 1'($urandom_range(0, 1));
    w.new_level     = LEVEL_W'($urandom);
    w.period_cycles = PERIOD_W'($urandom);
    w.cycles_left   = LEFT_W'($urandom);
    send_word(w, -1, 0, 0);
  endtask

  // One well-formed period: a few level changes with a shrinking countdown
  // (now and then a negative one), closed by an end-of-period word.
  task automatic rand_period(inout int sent);
    in_word_t    w;
    int unsigned per;
    int unsigned left;
    int          k;
    int          steps;
    per   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20'hFFFFF)
                                         : $urandom_range(1, 3000);
    left  = per;
    steps = $urandom_range(1, 6);
    for (k = 0; k < steps; k++) begin
      left            = $urandom_range(0, left);
      w.opcode        = OP_LEVEL;
      w.new_level     = LEVEL_W'($urandom);
      w.period_cycles = PERIOD_W'(per);
      if ($urandom_range(0, 9) == 0)
        w.cycles_left = LEFT_W'(-int'($urandom_range(1, 1 << 20)));
      else
        w.cycles_left = LEFT_W'(left);
      send_word(w, -1, 0, 0);
      sent++;
    end
    w.opcode        = OP_EOP;
    w.new_level     = LEVEL_W'($urandom);
    w.cycles_left   = LEFT_W'($urandom);
    send_word(w, -1, 0, 0);
    sent++;
  endtask

  // Receiver: random backpressure, none while calm.
  always @(negedge clk)
    pcm_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  // Sample checker: every taken word must match the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pcm_ch.valid && pcm_ch.ready) begin
      got_pcm.value = pcm_ch.sample_value;
      got_pcm.index = pcm_ch.sample_index;
      got_pcm.last  = pcm_ch.last_of_run;
      if (pending_pcm.size() == 0) begin
        note_mismatch("unexpected", '0, got_pcm);
      end else begin
        want_pcm = pending_pcm.pop_front();
        if (got_pcm.value !== want_pcm.value || got_pcm.index !== want_pcm.index ||
            got_pcm.last !== want_pcm.last)
          note_mismatch("mismatch", want_pcm, got_pcm);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : main
    int          i;
    int          ph;
    int          sent;
    int unsigned spp_plan[PHASES];

    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_data              = '0;
    calm                  = 1'b0;
    fail_count            = 0;
    item_ch.valid         = 1'b0;
    item_ch.opcode        = OP_LEVEL;
    item_ch.new_level     = '0;
    item_ch.period_cycles = '0;
    item_ch.cycles_left   = '0;
    pcm_ch.ready          = 1'b0;
    m_spp                 = 0;
    m_pos                 = 0;
    m_held                = '0;

    // Directed table. Register is zero out of reset: sound off.
    directed_tab.push_back(ev_row(OP_LEVEL, 63, 100, 0, 0, 0, 0));
    directed_tab.push_back(ev_row(OP_EOP, 63, 20'hFFFFF, -1, 0, 0, 0));
    directed_tab.push_back(cfg_row(64));
    // whole period elapsed, most negative countdown: full buffer of level 63
    directed_tab.push_back(ev_row(OP_LEVEL, 0, 20'hFFFFF, -1048576, 64, 0, 'h7E00));
    directed_tab.push_back(ev_row(OP_EOP, 0, 0, 0, 0, 0, 0));
    // zero period, then countdown equal to period: nothing
    directed_tab.push_back(ev_row(OP_LEVEL, 21, 0, 0, 0, 0, 0));
    directed_tab.push_back(ev_row(OP_LEVEL, 42, 1000, 1000, 0, 0, 0));
    // half way: samples 0..31 at level 42
    directed_tab.push_back(ev_row(OP_LEVEL, 5, 1000, 500, 32, 0, 'h5400));
    // target behind position: nothing
    directed_tab.push_back(ev_row(OP_LEVEL, 7, 1000, 700, 0, 0, 0));
    // largest positive countdown: nothing
    directed_tab.push_back(ev_row(OP_LEVEL, 9, 1000, 1048575, 0, 0, 0));
    // end of period fills 32..63 at level 9
    directed_tab.push_back(ev_row(OP_EOP, 0, 0, 0, 32, 32, 'h1200));
    directed_tab.push_back(ev_row(OP_LEVEL, 1, 1, 0, 64, 0, 'h1200));
    directed_tab.push_back(ev_row(OP_EOP, 0, 0, 0, 0, 0, 0));
    // register above 64 acts as 64
    directed_tab.push_back(cfg_row(100));
    directed_tab.push_back(ev_row(OP_LEVEL, 33, 3, 2, -1, 0, 0));
    directed_tab.push_back(ev_row(OP_EOP, 0, 0, 0, -1, 0, 0));
    directed_tab.push_back(cfg_row(127));
    directed_tab.push_back(ev_row(OP_LEVEL, 0, 20'hFFFFF, 1048574, 0, 0, 0));
    directed_tab.push_back(ev_row(OP_EOP, 0, 0, 0, 64, 0, 0));
    // one sample per period
    directed_tab.push_back(cfg_row(1));
    directed_tab.push_back(ev_row(OP_LEVEL, 63, 2, 1, 0, 0, 0));
    directed_tab.push_back(ev_row(OP_LEVEL, 10, 2, -5, 1, 0, 'h7E00));
    directed_tab.push_back(ev_row(OP_EOP, 0, 0, 0, 0, 0, 0));
    directed_tab.push_back(ev_row(OP_EOP, 0, 0, 0, 1, 0, 'h1400));
    // sound off again: level still latched, position still cleared
    directed_tab.push_back(cfg_row(0));
    directed_tab.push_back(ev_row(OP_LEVEL, 50, 10, 0, 0, 0, 0));
    directed_tab.push_back(ev_row(OP_EOP, 0, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_tab.size(); i++) begin
      if (directed_tab[i].is_cfg) begin
        settle();
        write_spp(directed_tab[i].spp);
      end else begin
        send_word(directed_tab[i].w, directed_tab[i].n_typed,
                  directed_tab[i].first_idx, directed_tab[i].value);
      end
    end

    // Random phases, each at its own register setting.
    spp_plan = '{64, 0, 1, 127, 65, 63, 0, 32, 0};
    spp_plan[6] = $urandom_range(2, 62);
    spp_plan[8] = $urandom_range(0, 127);
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_spp(spp_plan[ph]);
      calm = (ph == 3);  // one long stretch with no idling either side
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 29) == 0)
          wait_drained();  // sender holds off until output is empty
        if ($urandom_range(0, 4) == 0) begin
          rand_noise();
          sent++;
        end else begin
          rand_period(sent);
        end
      end
    end
    calm = 1'b0;

    settle();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/slpf_pkg.sv
design/slpf_in_if.sv
design/slpf_out_if.sv
design/slpf_ctrl.sv
design/slpf_dp.sv
design/speaker_level_to_pcm_filler.sv
bench/testbench.sv
